>>> sv/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// No dependencies; the interfaces, the top level and the rank table import this package.
package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_NUM_W  = 16;
    localparam int FRAME_IDX_W = 3;
    localparam int CFG_W       = 4;
    localparam int FAULT_W     = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    // Commands from the sequencer to the recency table.
    typedef struct packed {
        logic clear;
        logic apply;
        logic hit;
    } rank_cmd_t;

endpackage

>>> sv/lrupr_ifs.sv
// Handshake interfaces for the reference, result and configuration channels.
// Depends on lrupr_pkg for the field widths.
interface lrupr_ref_if
    import lrupr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PAGE_NUM_W-1:0] page_number;
    logic                  restart;

    modport source (output valid, page_number, restart, input ready);
    modport sink   (input valid, page_number, restart, output ready);
endinterface

interface lrupr_res_if
    import lrupr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_NUM_W-1:0]  evicted_page;
    logic [FAULT_W-1:0]     fault_total;

    modport source (output valid, hit, frame_index, evicted_valid, evicted_page,
                    fault_total, input ready);
    modport sink   (input valid, hit, frame_index, evicted_valid, evicted_page,
                    fault_total, output ready);
endinterface

interface lrupr_cfg_if
    import lrupr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/lru_page_replacement.sv
// Top level of the LRU page replacement block: sequencer, shared tag compare, fault count.
// Depends on lrupr_pkg, lrupr_ifs, lrupr_page_mem and lrupr_rank_table.
//
//   Channel   Dir   Payload                                                 Beat
//   ref_in    in    page_number, restart                                    valid & ready
//   res_out   out   hit, frame_index, evicted_valid, evicted_page, fault_total  valid & ready
//   cfg       in    data (frames_in_use)                                    valid & ready
//
// One reference scans from frame 0 up to frame k when it hits frame k, and through
// all n frames on a miss, n being the number of active frames: the single tag
// comparator visits one frame a cycle, fed by the tag store's one read port.
// ref_in is ready only between references. A stalled result holds the final update step.
// Reset clears the valid bits, ranks and fault count at once and sets frames_in_use to 8.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lrupr_ref_if.sink   ref_in,
    lrupr_res_if.source res_out,
    lrupr_cfg_if.sink   cfg
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     frames_cfg_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     n_eff;
    logic [PAGE_BITS-1:0] pg_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     hit_rank_reg;
    logic                 empty_found_reg;
    logic [IDX_W-1:0]     empty_idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_rank_reg;
    logic [PAGE_BITS-1:0] best_page_reg;
    logic [FAULT_W-1:0]   fault_reg;

    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [FRAME_IDX_W-1:0] out_idx_reg;
    logic                 out_ev_valid_reg;
    logic [PAGE_NUM_W-1:0] out_ev_page_reg;
    logic [FAULT_W-1:0]   out_fault_reg;

    logic                 accept;
    logic                 out_free;
    logic                 fire;
    logic                 last;
    logic                 match;
    logic                 miss_fire;
    logic [IDX_W-1:0]     sel;
    logic [IDX_W-1:0]     rank_i;
    logic                 valid_i;
    logic [PAGE_BITS-1:0] rd_page;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [FAULT_W-1:0]   fault_next;

    logic [FRAMES-1:0]            valid_vec;
    logic [FRAMES-1:0][IDX_W-1:0] rank_vec;
    rank_cmd_t                    cmd;

    assign accept   = ref_in.valid && ref_in.ready;
    assign out_free = !out_valid_reg || res_out.ready;
    assign fire     = (state_reg == S_UPDATE) && out_free;
    assign miss_fire = fire && !hit_reg;

    assign ref_in.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    // A zero frame count acts as one frame, and a count above the table acts as all of it.
    always_comb
    begin
        if (frames_cfg_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(frames_cfg_reg) > FRAMES)
        begin
            n_eff = CNT_W'(FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(frames_cfg_reg);
        end
    end

    // Shared compare unit: one frame's tag and rank per cycle.
    assign valid_i = valid_vec[idx_reg];
    assign rank_i  = rank_vec[idx_reg];
    assign match   = valid_i && (rd_page == pg_reg);
    assign last    = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_reg);

    assign rd_en   = accept || ((state_reg == S_SCAN) && !match && !last);
    assign rd_addr = accept ? '0 : (idx_reg + 1'b1);

    assign sel = hit_reg ? hit_idx_reg : (empty_found_reg ? empty_idx_reg : best_idx_reg);

    assign fault_next = (fault_reg == COUNT_MAX) ? fault_reg : (fault_reg + 1'b1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match || last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frames_cfg_reg <= CFG_RESET;
            fault_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                frames_cfg_reg <= cfg.data;
            end
            if (accept && ref_in.restart)
            begin
                fault_reg <= '0;
            end
            else if (miss_fire)
            begin
                fault_reg <= fault_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scan bookkeeping and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pg_reg          <= PAGE_BITS'(ref_in.page_number);
            n_reg           <= n_eff;
            idx_reg         <= '0;
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (match)
            begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= idx_reg;
                hit_rank_reg <= rank_i;
            end
            if (!valid_i && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= idx_reg;
            end
            // Strictly larger rank wins, so ties keep the lower frame.
            if ((idx_reg == '0) || (rank_i > best_rank_reg))
            begin
                best_idx_reg  <= idx_reg;
                best_rank_reg <= rank_i;
                best_page_reg <= rd_page;
            end
            idx_reg <= idx_reg + 1'b1;
        end
        if (fire)
        begin
            out_hit_reg      <= hit_reg;
            out_idx_reg      <= FRAME_IDX_W'(sel);
            out_ev_valid_reg <= !hit_reg && !empty_found_reg;
            out_ev_page_reg  <= (!hit_reg && !empty_found_reg)
                                ? PAGE_NUM_W'(best_page_reg) : '0;
            out_fault_reg    <= hit_reg ? fault_reg : fault_next;
        end
    end

    always_comb
    begin
        cmd.clear = accept && ref_in.restart;
        cmd.apply = fire;
        cmd.hit   = hit_reg;
    end

    lrupr_page_mem #(
        .DEPTH  (FRAMES),
        .ADDR_W (IDX_W),
        .DATA_W (PAGE_BITS)
    ) u_page_mem (
        .clk   (clk),
        .we    (miss_fire),
        .waddr (sel),
        .wdata (pg_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_page)
    );

    lrupr_rank_table #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W)
    ) u_rank_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sel      (sel),
        .hit_rank (hit_rank_reg),
        .active   (n_reg),
        .valid    (valid_vec),
        .rank     (rank_vec)
    );

    assign res_out.valid         = out_valid_reg;
    assign res_out.hit           = out_hit_reg;
    assign res_out.frame_index   = out_idx_reg;
    assign res_out.evicted_valid = out_ev_valid_reg;
    assign res_out.evicted_page  = out_ev_page_reg;
    assign res_out.fault_total   = out_fault_reg;

endmodule

>>> sv/lrupr_page_mem.sv
// Page tag store: one write port and one read port with registered read data.
// No dependencies.
module lrupr_page_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/lrupr_rank_table.sv
// Frame valid bits and recency ranks, with the aging rule applied to all frames at once.
// Depends on lrupr_pkg for the command struct.
module lrupr_rank_table
    import lrupr_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    parameter int IDX_W  = 3,
    parameter int CNT_W  = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rank_cmd_t                    cmd,
    input  logic [IDX_W-1:0]             sel,
    input  logic [IDX_W-1:0]             hit_rank,
    input  logic [CNT_W-1:0]             active,
    output logic [FRAMES-1:0]            valid,
    output logic [FRAMES-1:0][IDX_W-1:0] rank
);

    localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);

    logic [FRAMES-1:0]            valid_reg, valid_next;
    logic [FRAMES-1:0][IDX_W-1:0] rank_reg, rank_next;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (cmd.clear)
            begin
                valid_next[i] = 1'b0;
                rank_next[i]  = '0;
            end
            else if (cmd.apply)
            begin
                if (IDX_W'(i) == sel)
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if ((CNT_W'(i) < active) && valid_reg[i]
                         && (!cmd.hit || (rank_reg[i] < hit_rank))
                         && (rank_reg[i] < RANK_MAX))
                begin
                    // Valid active frames younger than a hit, or all on a miss, age.
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    assign valid = valid_reg;
    assign rank  = rank_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement: page references go in, lookup results are
// checked against an in-bench LRU frame table model. Also depends on lrupr_pkg and lrupr_ifs.
module tb;
    import lrupr_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_WAIT  = 24;
    localparam int REPORT_CAP   = 50;
    localparam int RANK_MAX     = FRAMES_DEF - 1;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame;
        logic                   ev_valid;
        logic [PAGE_NUM_W-1:0]  ev_page;
        logic [FAULT_W-1:0]     faults;
    } lookup_t;

    logic clk;
    logic rst_n;

    lrupr_ref_if ref_if ();
    lrupr_res_if res_if ();
    lrupr_cfg_if cfg_if ();

    lru_page_replacement u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .ref_in  (ref_if),
        .res_out (res_if),
        .cfg     (cfg_if)
    );

    // Model of the frame table.
    logic [PAGE_NUM_W-1:0] tbl_page  [FRAMES_DEF];
    logic                  tbl_valid [FRAMES_DEF];
    logic [2:0]            tbl_rank  [FRAMES_DEF];
    logic [FAULT_W-1:0]    tbl_faults;
    logic [CFG_W-1:0]      frames_cfg;

    lookup_t pending_lookups[$];
    int      mismatch_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      calm_left;
    logic [PAGE_NUM_W-1:0] page_pool[10];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic lookup_t predict_lookup(input logic [PAGE_NUM_W-1:0] page,
                                               input logic restart);
        lookup_t r;
        int      n;
        int      sel;
        int      i;
        r   = '0;
        sel = -1;
        n   = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES_DEF) ? FRAMES_DEF : int'(frames_cfg));
        if (restart)
        begin
            for (i = 0; i < FRAMES_DEF; i++)
            begin
                tbl_valid[i] = 1'b0;
                tbl_rank[i]  = '0;
            end
            tbl_faults = '0;
        end
        for (i = 0; i < n; i++)
            if (sel < 0 && tbl_valid[i] && tbl_page[i] == page)
                sel = i;
        if (sel >= 0)
        begin
            r.hit = 1'b1;
            // Only frames more recent than the hit frame grow older.
            for (i = 0; i < n; i++)
                if (i != sel && tbl_valid[i] && tbl_rank[i] < tbl_rank[sel]
                    && tbl_rank[i] < RANK_MAX)
                    tbl_rank[i]++;
        end
        else
        begin
            for (i = 0; i < n; i++)
                if (sel < 0 && !tbl_valid[i])
                    sel = i;
            if (sel < 0)
            begin
                sel = 0;
                for (i = 1; i < n; i++)
                    if (tbl_rank[i] > tbl_rank[sel])
                        sel = i;
                r.ev_valid = 1'b1;
                r.ev_page  = tbl_page[sel];
            end
            for (i = 0; i < n; i++)
                if (i != sel && tbl_valid[i] && tbl_rank[i] < RANK_MAX)
                    tbl_rank[i]++;
            tbl_page[sel]  = page;
            tbl_valid[sel] = 1'b1;
            if (tbl_faults != COUNT_MAX)
                tbl_faults++;
        end
        tbl_rank[sel] = '0;
        r.frame  = sel[FRAME_IDX_W-1:0];
        r.faults = tbl_faults;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Result side: check every beat against the oldest pending lookup, then pick the
    // next cycle's ready.
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: unexpected result beat, expected none actual frame %0d",
                             $time, res_if.frame_index);
            end
            else
            begin
                want = pending_lookups.pop_front();
                check_field("hit", want.hit, res_if.hit);
                check_field("frame_index", want.frame, res_if.frame_index);
                check_field("evicted_valid", want.ev_valid, res_if.evicted_valid);
                check_field("evicted_page", want.ev_page, res_if.evicted_page);
                check_field("fault_total", want.faults, res_if.fault_total);
            end
        end
        res_if.ready <= (calm_left > 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sends one reference. Valid stays high after the beat so that a following call
    // in the same step does not lower and raise it again.
    task automatic send_ref(input logic [PAGE_NUM_W-1:0] page, input logic restart);
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(49) == 0)
            calm_left = $urandom_range(10, 30);
        if (calm_left == 0 && $urandom_range(99) < send_idle_pct)
        begin
            ref_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        ref_if.valid       <= 1'b1;
        ref_if.page_number <= page;
        ref_if.restart     <= restart;
        do
            @(posedge clk);
        while (!ref_if.ready);
        pending_lookups.push_back(predict_lookup(page, restart));
    endtask

    task automatic wait_lookups_drained();
        ref_if.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        wait_lookups_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        frames_cfg = value;
        @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
    endtask

    // Fill, hit, evict and restart with all eight frames taking part.
    task automatic test_fill_and_evict();
        int i;
        send_ref(16'h0000, 1'b1);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        for (i = 1; i <= 6; i++)
            send_ref(PAGE_NUM_W'(i), 1'b0);
        send_ref(16'h8000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0003, 1'b0);
        send_ref(16'h7FFF, 1'b0);
        send_ref(16'h5A5A, 1'b1);
        send_ref(16'h5A5A, 1'b0);
        send_ref(16'hA5A5, 1'b0);
    endtask

    // Out-of-range counts, and frames outside the count keeping stale pages that
    // later duplicate a resident one.
    task automatic test_frame_count_limits();
        int i;
        write_frame_count(4'd0);
        send_ref(16'h1111, 1'b0);
        send_ref(16'h1111, 1'b0);
        send_ref(16'h2222, 1'b0);
        write_frame_count(4'd15);
        send_ref(16'h0100, 1'b1);
        for (i = 1; i < FRAMES_DEF; i++)
            send_ref(16'h0100 + PAGE_NUM_W'(i), 1'b0);
        write_frame_count(4'd2);
        send_ref(16'h0105, 1'b0);
        send_ref(16'h0107, 1'b0);
        send_ref(16'h0101, 1'b0);
        write_frame_count(4'd8);
        send_ref(16'h0105, 1'b0);
        send_ref(16'h0107, 1'b0);
        send_ref(16'h4444, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] counts[8];
        int ph;
        int k;
        int pick;
        logic [PAGE_NUM_W-1:0] page;
        counts = '{4'd8, 4'd1, 4'd15, 4'd5, 4'd0, 4'd3, 4'd9, 4'd7};
        for (ph = 0; ph < 8; ph++)
        begin
            write_frame_count(counts[ph]);
            set_idling(ph % 4);
            for (k = 0; k < 10; k++)
                page_pool[k] = PAGE_NUM_W'($urandom);
            page_pool[0] = 16'h0000;
            page_pool[1] = 16'hFFFF;
            for (k = 0; k < 190; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                    page = page_pool[$urandom_range(9)];
                else
                    page = PAGE_NUM_W'($urandom);
                send_ref(page, $urandom_range(99) < 2);
                // Now and then hold off until every result is back.
                if (k % 97 == 96)
                    wait_lookups_drained();
            end
        end
    endtask

    // Miss on every reference with one frame so that the fault count climbs on each one,
    // then restart and hit the freshly loaded page.
    task automatic test_fault_run();
        int i;
        write_frame_count(4'd1);
        set_idling(0);
        send_ref(16'h00AA, 1'b1);
        for (i = 1; i < 64; i++)
            send_ref(i[0] ? 16'h5500 : 16'h00AA, 1'b0);
        send_ref(16'h1234, 1'b1);
        send_ref(16'h1234, 1'b0);
    endtask

    initial
    begin
        int i;
        rst_n              = 1'b0;
        ref_if.valid       = 1'b0;
        ref_if.page_number = '0;
        ref_if.restart     = 1'b0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        mismatch_count     = 0;
        cycle_count        = 0;
        calm_left          = 0;
        for (i = 0; i < FRAMES_DEF; i++)
        begin
            tbl_page[i]  = '0;
            tbl_valid[i] = 1'b0;
            tbl_rank[i]  = '0;
        end
        tbl_faults = '0;
        frames_cfg = CFG_RESET;
        set_idling(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        set_idling(3);
        test_frame_count_limits();
        test_random_traffic();
        test_fault_run();
        wait_lookups_drained();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
sv/lrupr_pkg.sv
sv/lrupr_ifs.sv
sv/lrupr_page_mem.sv
sv/lrupr_rank_table.sv
sv/lru_page_replacement.sv
dv/tb.sv
